[hdl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache
// Op codes, status codes, neighbor states, defaults and the entry type.
// ----------------------------------------------------------------------------
package arpc_pkg;
	localparam int TableEntriesDef = 16;
	localparam int unsigned TimeoutReset = 60;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_AGE    = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NOTFOUND = 2'd1;
	localparam logic [1:0] STS_FULL     = 2'd2;

	localparam logic [1:0] NS_REACHABLE = 2'd1;
	localparam logic [1:0] NS_STALE     = 2'd2;

	localparam logic [0:0] REG_AGE_TIMEOUT = 1'd0;

	// one table entry as stored
	typedef struct packed {
		logic [31:0] key;
		logic [47:0] mac;
		logic [1:0]  state;
		logic [31:0] stamp;
	} entry_t;

	// write request from the sequencer to the table memory
	typedef struct packed {
		logic   en;
		entry_t data;
	} mem_wr_t;
endpackage

[hdl/arpc_table.sv]
// ----------------------------------------------------------------------------
// arpc_table: entry memory of the ARP cache
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_table import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic          clk,
	input  mem_wr_t       wr,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);
	entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/arp_cache_with_aging.sv]
// ----------------------------------------------------------------------------
// arp_cache_with_aging: ARP table with neighbor aging
// Tick and unknown ops pass from issue straight to done; lookup/insert/remove
//   walk the table, issuing a read per valid entry and checking it on arrival.
// Age sweep: a read and check per visited slot, a move per moved entry, set by
//   the single read port of the entry memory (read, then write back).
// One item at a time: the next beat is taken in the cycle after the result
//   is loaded. The result sits in an output register while the next item
//   is already accepted.
// Reset clears the count and clock and sets the timeout to its default; the memory needs no clearing.
// ----------------------------------------------------------------------------
module arp_cache_with_aging import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: op[2:0], ip_addr[34:3], mac_addr[82:35], entry_state[84:83]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,
	// m_tdata: status[1:0], found_mac[49:2], found_state[51:50],
	//          found_stamp[83:52], changed_count[88:84], used_entries[93:89]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam logic [2:0] S_IDLE   = 3'd0; // wait for a beat
	localparam logic [2:0] S_RD     = 3'd1; // read data of slot idx arrives
	localparam logic [2:0] S_MOVE   = 3'd2; // read data of last slot arrives
	localparam logic [2:0] S_DONE   = 3'd3; // put result into output reg
	localparam logic [2:0] S_ISSUE  = 3'd4; // issue read of slot idx

	logic [2:0]    state_q;
	logic [2:0]    op_q;
	logic [31:0]   ip_q;
	logic [47:0]   mac_q;
	logic [1:0]    est_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] used_q;
	logic [31:0]   now_q;
	logic [15:0]   timeout_q;
	logic [CW-1:0] chg_q;
	logic [1:0]    sts_q;
	entry_t        hit_q;
	logic          hit_v_q;

	logic          out_v_q;
	logic [95:0]   out_q;

	mem_wr_t       wr;
	logic [AW-1:0] waddr, raddr;
	entry_t        rdata;

	arpc_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
		.clk(clk), .wr(wr), .waddr(waddr), .raddr(raddr), .rdata(rdata)
	);

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_AGE_TIMEOUT) begin
			prdata = {16'd0, timeout_q};
		end
	end
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AGE_TIMEOUT);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	logic [31:0] age;
	logic        old;
	logic [CW-1:0] last;
	assign age  = now_q - rdata.stamp;
	assign old  = age >= {16'd0, timeout_q};
	assign last = used_q - CW'(1);

	// control and memory access
	always_comb begin
		wr = '0;
		wr.data = rdata;
		waddr = idx_q[AW-1:0];
		raddr = idx_q[AW-1:0];
		if (state_q == S_MOVE) begin
			wr.en = 1'b1; // move last entry into freed slot
		end else if (state_q == S_RD) begin
			if (op_q == OP_INSERT && rdata.key == ip_q) begin
				wr.en = 1'b1;
				wr.data = '{key: ip_q, mac: mac_q, state: est_q, stamp: now_q};
			end else if (op_q == OP_AGE && rdata.state == NS_REACHABLE && old) begin
				wr.en = 1'b1;
				wr.data.state = NS_STALE;
				wr.data.stamp = now_q;
			end else if ((op_q == OP_REMOVE && rdata.key == ip_q) ||
			             (op_q == OP_AGE && rdata.state == NS_STALE && old)) begin
				raddr = last[AW-1:0];
			end
		end else if (state_q == S_ISSUE && op_q == OP_INSERT && idx_q == used_q &&
		             used_q < CW'(TABLE_ENTRIES)) begin
			wr.en = 1'b1; // append
			wr.data = '{key: ip_q, mac: mac_q, state: est_q, stamp: now_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			now_q     <= '0;
			timeout_q <= 16'(TimeoutReset);
			out_v_q   <= 1'b0;
			op_q      <= '0;
			idx_q     <= '0;
			chg_q     <= '0;
			sts_q     <= STS_OK;
			hit_v_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				timeout_q <= pwdata[15:0];
			end
			// load a new result, or drop the one taken downstream
			if (state_q == S_DONE && (!out_v_q || m_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[2:0];
						ip_q    <= s_tdata[34:3];
						mac_q   <= s_tdata[82:35];
						est_q   <= s_tdata[84:83];
						idx_q   <= '0;
						chg_q   <= '0;
						sts_q   <= STS_OK;
						hit_v_q <= 1'b0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (op_q == OP_TICK) begin
						now_q <= now_q + 32'd1;
						state_q <= S_DONE;
					end else if (op_q > OP_TICK) begin
						state_q <= S_DONE;
					end else if (idx_q >= used_q) begin
						// walked past the valid range without a hit
						state_q <= S_DONE;
						case (op_q)
							OP_INSERT: begin
								if (used_q < CW'(TABLE_ENTRIES)) used_q <= used_q + CW'(1);
								else sts_q <= STS_FULL;
							end
							OP_LOOKUP, OP_REMOVE: sts_q <= STS_NOTFOUND;
							default: ;
						endcase
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (op_q == OP_AGE) begin
						if (rdata.state == NS_REACHABLE && old) begin
							chg_q   <= chg_q + CW'(1);
							idx_q   <= idx_q + CW'(1);
							state_q <= S_ISSUE;
						end else if (rdata.state == NS_STALE && old) begin
							// hold idx: the moved entry is checked again
							chg_q   <= chg_q + CW'(1);
							used_q  <= last;
							state_q <= (idx_q != last) ? S_MOVE : S_ISSUE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_ISSUE;
						end
					end else if (rdata.key == ip_q) begin
						if (op_q == OP_LOOKUP) begin
							hit_q   <= rdata;
							hit_v_q <= 1'b1;
							state_q <= S_DONE;
						end else if (op_q == OP_REMOVE) begin
							// hold idx: the last entry lands here
							used_q  <= last;
							state_q <= (idx_q != last) ? S_MOVE : S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_ISSUE;
					end
				end
				S_MOVE: begin
					state_q <= (op_q == OP_AGE) ? S_ISSUE : S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || m_tready) begin
						out_q <= {2'd0, 5'(used_q), 5'(chg_q),
							hit_v_q ? {hit_q.stamp, hit_q.state, hit_q.mac} : 82'd0,
							sts_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_ENTRIES)) else $error("used count over capacity");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !s_tvalid) |=> $stable(used_q))
		else $error("count moved while idle");
	a_move_from: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> ($past(state_q) == S_RD))
		else $error("move without a read");
endmodule

[bench/tb_arp_cache_with_aging.sv]
// ----------------------------------------------------------------------------
// tb_arp_cache_with_aging: self-checking bench of the ARP cache with aging
// Drives ARP operations as stream beats and predicts every result beat with
// its own table model. Covers insert, lookup, remove, age sweeps and ticks
// under random idling on both sides and several timeout settings.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_aging;
	import arpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NENT = 16;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] mac;
		logic [1:0]  state;
		logic [31:0] stamp;
		logic [4:0]  changed;
		logic [4:0]  used;
	} arp_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	arp_cache_with_aging uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table
	logic [31:0] tbl_ip [NENT];
	logic [47:0] tbl_mac [NENT];
	logic [1:0]  tbl_st [NENT];
	logic [31:0] tbl_stamp [NENT];
	int unsigned tbl_used = 0;
	logic [31:0] secs = '0;
	logic [15:0] timeout = 16'(TimeoutReset);

	arp_rsp_t rsp_queue[$];
	int errors = 0;
	int wdog = 0;
	bit quiet = 1'b0;  // no idling in the last part
	logic [31:0] ip_pool [8];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int find_ip(input logic [31:0] ip);
		for (int i = 0; i < int'(tbl_used); i++)
			if (tbl_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic void drop_entry(input int i);
		int last;
		last = int'(tbl_used) - 1;
		if (i != last) begin
			tbl_ip[i] = tbl_ip[last];
			tbl_mac[i] = tbl_mac[last];
			tbl_st[i] = tbl_st[last];
			tbl_stamp[i] = tbl_stamp[last];
		end
		tbl_used--;
	endfunction

	// compute the result of one op and advance the shadow table
	function automatic arp_rsp_t predict_arp(input logic [2:0] op, input logic [31:0] ip,
			input logic [47:0] mac, input logic [1:0] st);
		arp_rsp_t r;
		int idx;
		int i;
		logic [31:0] age;
		r = '0;
		case (op)
			OP_INSERT: begin
				idx = find_ip(ip);
				if (idx >= 0) begin
					tbl_mac[idx] = mac; tbl_st[idx] = st; tbl_stamp[idx] = secs;
				end else if (tbl_used >= NENT) begin
					r.status = STS_FULL;
				end else begin
					tbl_ip[tbl_used] = ip; tbl_mac[tbl_used] = mac;
					tbl_st[tbl_used] = st; tbl_stamp[tbl_used] = secs;
					tbl_used++;
				end
			end
			OP_LOOKUP: begin
				idx = find_ip(ip);
				if (idx < 0) begin
					r.status = STS_NOTFOUND;
				end else begin
					r.mac = tbl_mac[idx]; r.state = tbl_st[idx]; r.stamp = tbl_stamp[idx];
				end
			end
			OP_REMOVE: begin
				idx = find_ip(ip);
				if (idx < 0) r.status = STS_NOTFOUND;
				else drop_entry(idx);
			end
			OP_AGE: begin
				i = 0;
				while (i < int'(tbl_used)) begin
					age = secs - tbl_stamp[i];
					if (tbl_st[i] == NS_REACHABLE && age >= {16'd0, timeout}) begin
						tbl_st[i] = NS_STALE; tbl_stamp[i] = secs;
						r.changed++; i++;
					end else if (tbl_st[i] == NS_STALE && age >= {16'd0, timeout}) begin
						drop_entry(i); r.changed++;
					end else begin
						i++;
					end
				end
			end
			OP_TICK: secs = secs + 32'd1;
			default: ;
		endcase
		r.used = 5'(tbl_used);
		return r;
	endfunction

	// send one beat and queue its expected result; valid stays up between
	// back-to-back beats and drops only for an idle burst or a drain
	task automatic send_op(input logic [2:0] op, input logic [31:0] ip,
			input logic [47:0] mac, input logic [1:0] st);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'd0, st, mac, ip, op};
		do @(posedge clk); while (!s_tready);
		rsp_queue.push_back(predict_arp(op, ip, mac, st));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (rsp_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// write the timeout register while the block is idle
	task automatic set_timeout(input logic [15:0] val);
		drain();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {REG_AGE_TIMEOUT, 2'b00}; pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		timeout = val;
	endtask

	function automatic logic [47:0] rand_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic ticks(input int n);
		repeat (n) send_op(OP_TICK, $urandom, rand_mac(), 2'($urandom));
	endtask

	// extremes, insert, lookup and remove, full table, missing address, unknown ops
	task automatic test_directed();
		send_op(OP_LOOKUP, 32'h0, '0, 2'd0);
		send_op(OP_REMOVE, 32'hFFFF_FFFF, '0, 2'd0);
		send_op(OP_INSERT, 32'h0, 48'h0, 2'd0);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3);
		send_op(OP_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 2'd1);
		send_op(OP_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0);
		for (int i = 0; i < 15; i++) send_op(OP_INSERT, 32'h0A00_0000 + i, rand_mac(), 2'(i));
		send_op(OP_INSERT, 32'hC0A8_0001, rand_mac(), 2'd1);
		send_op(OP_INSERT, 32'h0, rand_mac(), 2'd2);
		send_op(OP_REMOVE, 32'h0, '0, 2'd0);
		send_op(3'd5, 32'h1, rand_mac(), 2'd1);
		send_op(3'd7, 32'hFFFF_FFFF, '1, 2'd3);
		send_op(OP_LOOKUP, 32'h0A00_000E, '0, 2'd0);
	endtask

	// zero timeout: reachable go stale, stale get removed, two sweeps remove both kinds
	task automatic test_zero_timeout();
		set_timeout(16'd0);
		send_op(OP_AGE, '0, '0, 2'd0);
		send_op(OP_AGE, '0, '0, 2'd0);
		send_op(3'd6, '0, '0, 2'd0);
	endtask

	// small timeout with ticks, including the counter around a sweep
	task automatic test_aging_small();
		set_timeout(16'd3);
		for (int i = 0; i < 10; i++)
			send_op(OP_INSERT, 32'h0B00_0000 + i, rand_mac(), 2'($urandom_range(1, 2)));
		for (int k = 0; k < 6; k++) begin
			ticks(1);
			send_op(OP_AGE, '0, '0, 2'd0);
		end
		// hold off until everything is back
		drain();
	endtask

	// random mix, mostly hitting a small address pool
	task automatic test_random(input int n);
		logic [2:0] op;
		logic [31:0] ip;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) op = OP_INSERT;
			else if (pick < 55) op = OP_LOOKUP;
			else if (pick < 68) op = OP_REMOVE;
			else if (pick < 78) op = OP_AGE;
			else if (pick < 97) op = OP_TICK;
			else op = 3'($urandom_range(5, 7));
			ip = ($urandom_range(0, 9) < 8) ? ip_pool[$urandom_range(0, 7)] : $urandom;
			send_op(op, ip, rand_mac(), 2'($urandom));
		end
	endtask

	// ready side: random stall bursts until the quiet part
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		arp_rsp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '0;
			got.status = m_tdata[1:0];
			got.mac = m_tdata[49:2];
			got.state = m_tdata[51:50];
			got.stamp = m_tdata[83:52];
			got.changed = m_tdata[88:84];
			got.used = m_tdata[93:89];
			if (rsp_queue.size() == 0) begin
				report("unexpected beat", m_tdata[63:0], 64'd0);
			end else begin
				want = rsp_queue.pop_front();
				if (got.status != want.status)
					report("status", 64'(got.status), 64'(want.status));
				if (got.mac != want.mac)
					report("found_mac", 64'(got.mac), 64'(want.mac));
				if (got.state != want.state)
					report("found_state", 64'(got.state), 64'(want.state));
				if (got.stamp != want.stamp)
					report("found_stamp", 64'(got.stamp), 64'(want.stamp));
				if (got.changed != want.changed)
					report("changed_count", 64'(got.changed), 64'(want.changed));
				if (got.used != want.used)
					report("used_entries", 64'(got.used), 64'(want.used));
			end
		end
	end

	// watchdog: count cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			wdog <= 0;
		end else if (wdog >= WDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			wdog <= wdog + 1;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++) ip_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_timeout();
		test_aging_small();
		set_timeout(16'd2);
		test_random(150);
		set_timeout(16'hFFFF);
		test_random(100);
		set_timeout(16'd5);
		test_random(100);
		quiet = 1'b1;
		test_random(60);
		drain();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
